FILE: rtl/core/hdlc_afsk_bit_encoder_defines.svh
// assertion macros for the hdlc afsk bit encoder
`ifndef HDLC_AFSK_BIT_ENCODER_DEFINES_SVH
`define HDLC_AFSK_BIT_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS
`define HAFSK_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hafsk assertion failed");
`define HAFSK_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hafsk assertion failed");
`else
`define HAFSK_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HAFSK_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/core/hafsk_pkg.sv
package hafsk_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [15:0] CRC_POLY   = 16'h8408;
    localparam logic [15:0] CRC_PRESET = 16'hFFFF;

    localparam logic [1:0] FUNC_BYTE  = 2'd0;
    localparam logic [1:0] FUNC_FCS   = 2'd1;
    localparam logic [1:0] FUNC_BEGIN = 2'd2;

    typedef logic [4:0] t_bitcnt;
    localparam t_bitcnt BYTE_BITS = 5'd8;
    localparam t_bitcnt FCS_BITS  = 5'd16;

    localparam logic [2:0] ONES_LIMIT = 3'd4;

    typedef enum logic [1:0] {
        OP_DATA,
        OP_FLAG,
        OP_FCS,
        OP_BEGIN
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
    } t_cmd;

endpackage

FILE: rtl/core/hafsk_if.sv
interface hafsk_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] data_byte;
    logic       is_flag;

    modport source (output valid, output func, output data_byte, output is_flag, input ready);
    modport sink   (input valid, input func, input data_byte, input is_flag, output ready);
endinterface

interface hafsk_out_if;
    logic valid;
    logic ready;
    logic tone;
    logic stuffed;
    logic last;

    modport source (output valid, output tone, output stuffed, output last, input ready);
    modport sink   (input valid, input tone, input stuffed, input last, output ready);
endinterface

FILE: rtl/core/hdlc_afsk_bit_encoder.sv
// AX.25 HDLC transmit bit encoder for a 1200/2200 Hz AFSK modulator. Each
// input word is a command: send a byte LSB first (as data, or as a flag with
// no crc and no stuffing), append the fcs (complemented crc-16, low byte
// first), or begin a frame (crc preset, ones run cleared, no output). Each
// output word is one NRZI tone symbol, with a mark for stuff bits and for the
// last symbol of its command. The serializer sends one symbol per cycle
// while its output register is empty or being taken, and it sends no symbol
// in a cycle in which it loads a command; a small command queue lets new
// words be taken while symbols of earlier ones still go out.
module hdlc_afsk_bit_encoder #(
    parameter int unsigned P_QUEUE_DEPTH = hafsk_pkg::QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hafsk_in_if.sink     i_in,
    hafsk_out_if.source  o_out
);

    logic            w_push;
    logic            w_pop;
    logic            w_full;
    logic            w_empty;
    hafsk_pkg::t_cmd w_cmd;
    hafsk_pkg::t_cmd w_head;

    hafsk_front u_front (
        .i_in   (i_in),
        .i_full (w_full),
        .o_push (w_push),
        .o_cmd  (w_cmd)
    );

    hafsk_queue #(
        .Depth (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    hafsk_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

FILE: rtl/core/hafsk_front.sv
module hafsk_front (
    hafsk_in_if.sink         i_in,
    input  logic             i_full,
    output logic             o_push,
    output hafsk_pkg::t_cmd  o_cmd
);

    logic w_keep;

    assign i_in.ready = !i_full;

    // classify the command word
    always_comb begin
        w_keep     = 1'b1;
        o_cmd.data = i_in.data_byte;
        o_cmd.op   = hafsk_pkg::OP_DATA;
        case (i_in.func)
            hafsk_pkg::FUNC_BYTE: begin
                o_cmd.op = i_in.is_flag ? hafsk_pkg::OP_FLAG : hafsk_pkg::OP_DATA;
            end
            hafsk_pkg::FUNC_FCS: begin
                o_cmd.op = hafsk_pkg::OP_FCS;
            end
            hafsk_pkg::FUNC_BEGIN: begin
                o_cmd.op = hafsk_pkg::OP_BEGIN;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    // unused codes are taken and dropped
    assign o_push = i_in.valid && !i_full && w_keep;

endmodule

FILE: rtl/core/hafsk_queue.sv
`include "hdlc_afsk_bit_encoder_defines.svh"

module hafsk_queue #(
    parameter int unsigned Depth = hafsk_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hafsk_pkg::t_cmd i_cmd,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output hafsk_pkg::t_cmd o_head
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    hafsk_pkg::t_cmd r_mem [Depth];
    logic [PtrW-1:0] r_wr, n_wr;
    logic [PtrW-1:0] r_rd, n_rd;
    logic [CntW-1:0] r_count, n_count;

    assign o_full  = (r_count == CntW'(Depth));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PtrW'(Depth - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PtrW'(Depth - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    `HAFSK_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CntW'(Depth))
    `HAFSK_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, i_push, !o_full)
    `HAFSK_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, i_pop, !o_empty)

endmodule

FILE: rtl/core/hafsk_back.sv
`include "hdlc_afsk_bit_encoder_defines.svh"

module hafsk_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hafsk_pkg::t_cmd i_head,
    input  logic            i_empty,
    output logic            o_pop,
    hafsk_out_if.source     o_out
);

    logic [15:0]        r_crc, n_crc;
    logic [2:0]         r_ones, n_ones;
    logic               r_tone, n_tone;
    logic [15:0]        r_shift, n_shift;
    hafsk_pkg::t_bitcnt r_cnt, n_cnt;
    logic               r_flag, n_flag;
    logic               r_stuff_pend, n_stuff_pend;

    logic r_out_valid, n_out_valid;
    logic r_out_tone, n_out_tone;
    logic r_out_stuffed, n_out_stuffed;
    logic r_out_last, n_out_last;

    logic w_busy;
    logic w_adv;
    logic w_emit;
    logic w_bit;
    logic w_fb;
    logic w_stuff_now;
    logic w_sym_stuffed;
    logic w_sym_last;

    assign w_busy = (r_cnt != '0) || r_stuff_pend;
    assign w_adv  = !r_out_valid || o_out.ready;
    assign w_emit = w_busy && w_adv;
    assign o_pop  = !w_busy && !i_empty;

    assign w_bit       = r_shift[0];
    assign w_fb        = r_crc[0] ^ w_bit;
    assign w_stuff_now = !r_flag && w_bit && (r_ones == hafsk_pkg::ONES_LIMIT);

    always_comb begin
        n_crc         = r_crc;
        n_ones        = r_ones;
        n_tone        = r_tone;
        n_shift       = r_shift;
        n_cnt         = r_cnt;
        n_flag        = r_flag;
        n_stuff_pend  = r_stuff_pend;
        w_sym_stuffed = 1'b0;
        w_sym_last    = 1'b0;
        if (o_pop) begin
            case (i_head.op)
                hafsk_pkg::OP_DATA: begin
                    n_shift = {8'h00, i_head.data};
                    n_cnt   = hafsk_pkg::BYTE_BITS;
                    n_flag  = 1'b0;
                end
                hafsk_pkg::OP_FLAG: begin
                    n_shift = {8'h00, i_head.data};
                    n_cnt   = hafsk_pkg::BYTE_BITS;
                    n_flag  = 1'b1;
                end
                hafsk_pkg::OP_FCS: begin
                    // fcs is taken once, low byte goes out first
                    n_shift = ~r_crc;
                    n_cnt   = hafsk_pkg::FCS_BITS;
                    n_flag  = 1'b0;
                end
                hafsk_pkg::OP_BEGIN: begin
                    n_crc  = hafsk_pkg::CRC_PRESET;
                    n_ones = '0;
                end
                default: begin
                    n_cnt = r_cnt;
                end
            endcase
        end else if (w_emit) begin
            if (r_stuff_pend) begin
                n_tone        = ~r_tone;
                n_ones        = '0;
                n_stuff_pend  = 1'b0;
                w_sym_stuffed = 1'b1;
                w_sym_last    = (r_cnt == '0);
            end else begin
                n_shift = {1'b0, r_shift[15:1]};
                n_cnt   = r_cnt - 1'b1;
                if (!r_flag) begin
                    n_crc = {1'b0, r_crc[15:1]} ^ (w_fb ? hafsk_pkg::CRC_POLY : 16'h0000);
                end
                if (w_bit) begin
                    if (r_flag) begin
                        n_ones = 3'd1;
                    end else if (w_stuff_now) begin
                        n_ones       = '0;
                        n_stuff_pend = 1'b1;
                    end else begin
                        n_ones = r_ones + 3'd1;
                    end
                end else begin
                    n_tone = ~r_tone;
                    n_ones = '0;
                end
                w_sym_last = (r_cnt == hafsk_pkg::t_bitcnt'(1)) && !w_stuff_now;
            end
        end
    end

    // output register, reloads whenever it is empty or being taken
    always_comb begin
        n_out_valid   = r_out_valid;
        n_out_tone    = r_out_tone;
        n_out_stuffed = r_out_stuffed;
        n_out_last    = r_out_last;
        if (w_adv) begin
            n_out_valid = w_emit;
        end
        if (w_emit) begin
            n_out_tone    = n_tone;
            n_out_stuffed = w_sym_stuffed;
            n_out_last    = w_sym_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc        <= hafsk_pkg::CRC_PRESET;
            r_ones       <= '0;
            r_tone       <= 1'b0;
            r_cnt        <= '0;
            r_flag       <= 1'b0;
            r_stuff_pend <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_crc        <= n_crc;
            r_ones       <= n_ones;
            r_tone       <= n_tone;
            r_cnt        <= n_cnt;
            r_flag       <= n_flag;
            r_stuff_pend <= n_stuff_pend;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift       <= n_shift;
        r_out_tone    <= n_out_tone;
        r_out_stuffed <= n_out_stuffed;
        r_out_last    <= n_out_last;
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.tone    = r_out_tone;
    assign o_out.stuffed = r_out_stuffed;
    assign o_out.last    = r_out_last;

    `HAFSK_ASSERT_IMP(a_stuff_clean, i_clk, i_rst_n, r_stuff_pend, (r_ones == '0) && !r_flag)
    `HAFSK_ASSERT_IMP(a_ones_bound, i_clk, i_rst_n, 1'b1, r_ones <= hafsk_pkg::ONES_LIMIT)
    `HAFSK_ASSERT_NXT(a_stuff_out, i_clk, i_rst_n, w_emit && r_stuff_pend, r_out_valid && r_out_stuffed)
    `HAFSK_ASSERT_IMP(a_pop_idle, i_clk, i_rst_n, o_pop, !w_emit)

endmodule

FILE: dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned TAIL_CYCLES = 40;
    localparam int unsigned HOLD_CYCLES = 300;

    typedef struct packed {
        logic tone;
        logic stuffed;
        logic last;
    } t_symbol;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hafsk_in_if  in_if ();
    hafsk_out_if out_if ();

    hdlc_afsk_bit_encoder i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #10ns i_clk = 1'b1;
        #10ns i_clk = 1'b0;
    end

    // encoder state mirror
    logic [15:0] crc_acc;
    logic [2:0]  ones_cnt;
    logic        line_tone;
    t_symbol     symbol_q[$];

    int unsigned errors;
    int unsigned symbol_words;
    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    int unsigned hold_req;
    int unsigned stall_cnt;

    function automatic void push_symbol(input logic stuffed_bit);
        t_symbol s;
        s.tone = line_tone;
        s.stuffed = stuffed_bit;
        s.last = 1'b0;
        symbol_q.push_back(s);
    endfunction

    function automatic void shift_byte(input logic [7:0] byte_v, input logic flag_v);
        logic b;
        logic fb;
        for (int i = 0; i < 8; i++) begin
            b = byte_v[i];
            if (flag_v) begin
                ones_cnt = 3'd0;
            end else begin
                fb = crc_acc[0] ^ b;
                crc_acc = crc_acc >> 1;
                if (fb) begin
                    crc_acc = crc_acc ^ hafsk_pkg::CRC_POLY;
                end
            end
            if (!b) begin
                line_tone = ~line_tone;
                push_symbol(1'b0);
                ones_cnt = 3'd0;
            end else begin
                push_symbol(1'b0);
                ones_cnt = ones_cnt + 3'd1;
                if (ones_cnt == 3'd5) begin
                    line_tone = ~line_tone;
                    push_symbol(1'b1);
                    ones_cnt = 3'd0;
                end
            end
        end
    endfunction

    function automatic bit predict_symbols(input logic [1:0] func, input logic [7:0] data,
                                           input logic flag);
        int n0;
        logic [7:0] fcs_lo;
        logic [7:0] fcs_hi;
        n0 = symbol_q.size();
        case (func)
            hafsk_pkg::FUNC_BYTE: begin
                shift_byte(data, flag);
            end
            hafsk_pkg::FUNC_FCS: begin
                fcs_lo = crc_acc[7:0] ^ 8'hFF;
                fcs_hi = crc_acc[15:8] ^ 8'hFF;
                shift_byte(fcs_lo, 1'b0);
                shift_byte(fcs_hi, 1'b0);
            end
            hafsk_pkg::FUNC_BEGIN: begin
                crc_acc = hafsk_pkg::CRC_PRESET;
                ones_cnt = 3'd0;
            end
            default: begin
            end
        endcase
        if (symbol_q.size() > n0) begin
            symbol_q[symbol_q.size() - 1].last = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic send_word(input logic [1:0] func, input logic [7:0] data, input logic flag);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.func <= func;
        in_if.data_byte <= data;
        in_if.is_flag <= flag;
        do @(posedge i_clk); while (!in_if.ready);
        if (predict_symbols(func, data, flag)) begin
            symbol_words++;
        end
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (symbol_q.size() != 0);
    endtask

    function automatic logic [7:0] pick_data();
        case ($urandom_range(3))
            0: return 8'($urandom | $urandom);
            1: return FLAG_BYTE;
            default: return 8'($urandom);
        endcase
    endfunction

    // receiver side, random stalls plus long hold-off on request
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left != 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end else begin
                out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_symbol got;
        t_symbol exp;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.tone = out_if.tone;
            got.stuffed = out_if.stuffed;
            got.last = out_if.last;
            if (symbol_q.size() == 0) begin
                $display("%0t unexpected word tone=%0b stuffed=%0b last=%0b",
                         $time, got.tone, got.stuffed, got.last);
                errors++;
            end else begin
                exp = symbol_q.pop_front();
                if (got != exp) begin
                    $display({"%0t exp tone=%0b stuffed=%0b last=%0b",
                              " got tone=%0b stuffed=%0b last=%0b"},
                             $time, exp.tone, exp.stuffed, exp.last,
                             got.tone, got.stuffed, got.last);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("hdlc_afsk_bit_encoder: mismatch");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    task automatic test_directed();
        send_word(hafsk_pkg::FUNC_BEGIN, 8'hA5, 1'b1);
        send_word(hafsk_pkg::FUNC_FCS, 8'h00, 1'b1);
        send_word(hafsk_pkg::FUNC_BYTE, FLAG_BYTE, 1'b1);
        send_word(hafsk_pkg::FUNC_BEGIN, 8'h00, 1'b0);
        send_word(hafsk_pkg::FUNC_BYTE, 8'h00, 1'b0);
        send_word(hafsk_pkg::FUNC_BYTE, 8'hFF, 1'b0);
        send_word(hafsk_pkg::FUNC_BYTE, FLAG_BYTE, 1'b0);
        send_word(hafsk_pkg::FUNC_BYTE, 8'h1F, 1'b0);
        send_word(hafsk_pkg::FUNC_BYTE, 8'hF8, 1'b0);
        send_word(hafsk_pkg::FUNC_BYTE, 8'h55, 1'b0);
        send_word(hafsk_pkg::FUNC_BYTE, 8'hAA, 1'b0);
        send_word(FUNC_NONE, 8'hFF, 1'b1);
        send_word(FUNC_NONE, 8'h00, 1'b0);
        send_word(hafsk_pkg::FUNC_FCS, 8'hFF, 1'b0);
        send_word(hafsk_pkg::FUNC_BYTE, 8'hFF, 1'b1);
        send_word(hafsk_pkg::FUNC_BYTE, 8'hFF, 1'b0);
        send_word(hafsk_pkg::FUNC_BYTE, 8'h00, 1'b1);
        send_word(hafsk_pkg::FUNC_BEGIN, 8'hFF, 1'b0);
        send_word(hafsk_pkg::FUNC_BYTE, 8'hFF, 1'b0);
        send_word(hafsk_pkg::FUNC_BYTE, 8'hFF, 1'b0);
        send_word(hafsk_pkg::FUNC_FCS, 8'h7E, 1'b1);
        send_word(hafsk_pkg::FUNC_BYTE, FLAG_BYTE, 1'b1);
        wait_drained();
    endtask

    task automatic test_frames(input int unsigned tx_pct, input int unsigned rx_pct,
                               input int unsigned target);
        int unsigned stop_at;
        int unsigned n;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        stop_at = symbol_words + target;
        while (symbol_words < stop_at) begin
            if ($urandom_range(99) < 80) begin
                send_word(hafsk_pkg::FUNC_BEGIN, 8'($urandom), 1'($urandom));
                n = $urandom_range(1, 2);
                repeat (n) send_word(hafsk_pkg::FUNC_BYTE, FLAG_BYTE, 1'b1);
                n = $urandom_range(1, 8);
                repeat (n) send_word(hafsk_pkg::FUNC_BYTE, pick_data(), 1'b0);
                send_word(hafsk_pkg::FUNC_FCS, 8'($urandom), 1'($urandom));
                send_word(hafsk_pkg::FUNC_BYTE, FLAG_BYTE, 1'b1);
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) send_word(2'($urandom_range(3)), 8'($urandom), 1'($urandom));
            end
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 30;
        hold_req = HOLD_CYCLES;
        send_word(hafsk_pkg::FUNC_BEGIN, 8'h00, 1'b0);
        repeat (20) send_word(hafsk_pkg::FUNC_BYTE, pick_data(), $urandom_range(3) == 0);
        send_word(hafsk_pkg::FUNC_FCS, 8'h00, 1'b0);
        wait_drained();
        send_word(hafsk_pkg::FUNC_BYTE, FLAG_BYTE, 1'b1);
        wait_drained();
    endtask

    initial begin
        errors = 0;
        symbol_words = 0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req = 0;
        stall_cnt = 0;
        crc_acc = hafsk_pkg::CRC_PRESET;
        ones_cnt = 3'd0;
        line_tone = 1'b0;
        i_rst_n <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.func <= hafsk_pkg::FUNC_BYTE;
        in_if.data_byte <= 8'h00;
        in_if.is_flag <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 17;
        rx_idle_pct = 66;
        test_directed();
        test_frames(17, 66, 105);
        test_backpressure();
        test_frames(66, 17, 115);
        test_frames(0, 0, 115);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0 && symbol_q.size() == 0) begin
            $display("hdlc_afsk_bit_encoder: match");
        end else begin
            $display("hdlc_afsk_bit_encoder: mismatch");
        end
        $finish;
    end
endmodule
